>>> rtl/core/cdhri_pkg.sv
// Package with the opcodes, port and bank codes and field constants of the disc host registers.
`timescale 1ns / 1ps
`default_nettype none

package cdhri_pkg;

  // Item opcodes.
  localparam logic [2:0] OP_BUS_READ      = 3'd0;
  localparam logic [2:0] OP_BUS_WRITE     = 3'd1;
  localparam logic [2:0] OP_DMA_READ      = 3'd2;
  localparam logic [2:0] OP_PUSH_RESPONSE = 3'd3;
  localparam logic [2:0] OP_PUSH_DATA     = 3'd4;
  localparam logic [2:0] OP_RAISE_FLAG    = 3'd5;
  localparam logic [2:0] OP_POP_PARAM     = 3'd6;

  // Byte ports of the register window.
  localparam logic [1:0] PORT_STATUS   = 2'd0;
  localparam logic [1:0] PORT_RESPONSE = 2'd1;
  localparam logic [1:0] PORT_DATA     = 2'd2;
  localparam logic [1:0] PORT_IRQ      = 2'd3;

  // Bank index values.
  localparam logic [1:0] BANK0 = 2'd0;
  localparam logic [1:0] BANK1 = 2'd1;
  localparam logic [1:0] BANK2 = 2'd2;
  localparam logic [1:0] BANK3 = 2'd3;

  // Source of the read data of an item in the read stage.
  localparam logic [1:0] SRC_IMM   = 2'd0;
  localparam logic [1:0] SRC_RESP  = 2'd1;
  localparam logic [1:0] SRC_PARAM = 2'd2;
  localparam logic [1:0] SRC_SECT  = 2'd3;

  // Interrupt register fields.
  localparam logic [7:0] IRQ_READ_ONES = 8'hE0;
  localparam logic [4:0] FLAG_HI_MASK  = 5'h18;
  localparam int         FLAG_END      = 3;
  localparam int         FLAG_ERROR    = 4;
  localparam logic [2:0] ACK_LOWEST    = 3'b111;
  localparam int         ACK_FLUSH_BIT = 6;
  localparam int         APPLY_BIT     = 5;
  localparam logic [7:0] FLAG_NUM_MIN  = 8'd1;
  localparam logic [7:0] FLAG_NUM_MAX  = 8'd5;

  // Number (1..5) of the lowest set flag, or zero when none is set.
  function automatic logic [2:0] lowest_flag(input logic [4:0] f);
    logic [2:0] n;
    n = 3'd0;
    if (f[0]) n = 3'd1;
    else if (f[1]) n = 3'd2;
    else if (f[2]) n = 3'd3;
    else if (f[3]) n = 3'd4;
    else if (f[4]) n = 3'd5;
    return n;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/cdhri_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module cdhri_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/cdrom_host_register_interface_unit.sv
// Top level of the disc controller host register window with its byte FIFOs.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one beat per cycle on the input channel: a bus read or write of one of the
// four byte ports, a four-byte DMA read of the data FIFO, or a side event from the controller
// core (push a response byte, push a data byte, raise an interrupt flag, pop a parameter
// byte). Every beat gives exactly one result beat: when the beat is accepted, all state is
// updated and the FIFO memories are read; the read stage then assembles the read data and
// places it in a two-entry output buffer. The sustained rate is one beat per clock; the
// input stalls only when both output buffer entries hold results that have not been taken
// and a third result sits in the read stage. The data FIFO is held in four byte-wide RAM
// banks, interleaved by the low two bits of the FIFO index, so that a DMA read reads its
// four bytes at once with one read port per bank; SECTOR_DEPTH must therefore be a multiple
// of four. FIFOs are cleared by resetting their pointers and counts only, so no clearing pass is
// needed after reset. Pushes into a full FIFO are dropped and reads of an empty FIFO return zero.
module cdrom_host_register_interface_unit
  import cdhri_pkg::*;
#(
  parameter int PARAM_DEPTH    = 16,
  parameter int RESPONSE_DEPTH = 16,
  parameter int SECTOR_DEPTH   = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  opcode,
  input  wire logic [1:0]  reg_offset,
  input  wire logic [7:0]  write_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] read_data,
  output logic             command_valid,
  output logic      [7:0]  command_code,
  output logic             irq_line,
  output logic      [7:0]  vol_left_to_left,
  output logic      [7:0]  vol_left_to_right,
  output logic      [7:0]  vol_right_to_left,
  output logic      [7:0]  vol_right_to_right,
  output logic             adpcm_mute
);

  localparam int PW   = $clog2(PARAM_DEPTH);
  localparam int PCW  = $clog2(PARAM_DEPTH + 1);
  localparam int RW   = $clog2(RESPONSE_DEPTH);
  localparam int RCW  = $clog2(RESPONSE_DEPTH + 1);
  localparam int SW   = $clog2(SECTOR_DEPTH);
  localparam int SCW  = $clog2(SECTOR_DEPTH + 1);
  localparam int ROWS = SECTOR_DEPTH / 4;

  // Item in the read stage: everything but the memory read data, which sits in the RAMs.
  typedef struct packed {
    logic [1:0] src;
    logic [7:0] imm;
    logic [1:0] lane;
    logic [2:0] nbytes;
    logic       cmd_valid;
    logic [7:0] cmd_code;
    logic       irq;
    logic [7:0] vol0;
    logic [7:0] vol1;
    logic [7:0] vol2;
    logic [7:0] vol3;
    logic       mute;
  } stage_t;

  // One finished result beat.
  typedef struct packed {
    logic [31:0] rd;
    logic        cmd_valid;
    logic [7:0]  cmd_code;
    logic        irq;
    logic [7:0]  vol0;
    logic [7:0]  vol1;
    logic [7:0]  vol2;
    logic [7:0]  vol3;
    logic        mute;
  } result_t;

  // Architectural state.
  logic [1:0]     bank_index,   bank_index_next;
  logic [4:0]     irq_enables,  irq_enables_next;
  logic [4:0]     irq_flags,    irq_flags_next;
  logic [7:0]     volume_latches  [4];
  logic [7:0]     volume_latches_next [4];
  logic [7:0]     volumes_applied [4];
  logic [7:0]     volumes_applied_next [4];
  logic           mute_bit,     mute_bit_next;

  logic [PW-1:0]  p_head, p_tail;
  logic [PCW-1:0] param_count;
  logic [RW-1:0]  r_head, r_tail;
  logic [RCW-1:0] response_count;
  logic [SW-1:0]  s_head, s_tail;
  logic [SCW-1:0] sector_count;

  // Read stage and output buffer.
  logic           a_valid;
  stage_t         a_stage, a_stage_next;
  logic           a_move;
  result_t        q0, q1, asm_result;
  logic [1:0]     q_count;
  logic           out_pop;

  // Decode.
  logic           accept;
  logic           p_empty, p_full, r_nonempty, r_full, s_nonempty, s_full;
  logic           p_push, p_pop, p_flush, r_push, r_pop, s_push;
  logic [2:0]     s_pop_n;
  logic [1:0]     src;
  logic [7:0]     imm;
  logic           cmd_v;
  logic [7:0]     cmd_c;

  // Memory data.
  logic [7:0]     param_q, resp_q;
  logic [7:0]     sect_q [4];
  logic [SW:0]    s_idx [4];
  logic [SW:0]    s_head_sum;

  assign accept   = in_valid && !in_stall;
  assign in_stall = a_valid && (q_count == 2'd2);

  assign p_empty    = (param_count == '0);
  assign p_full     = (param_count == PCW'(PARAM_DEPTH));
  assign r_nonempty = (response_count != '0);
  assign r_full     = (response_count == RCW'(RESPONSE_DEPTH));
  assign s_nonempty = (sector_count != '0);
  assign s_full     = (sector_count == SCW'(SECTOR_DEPTH));

  // Decode of one item and the next values of the register state.
  always_comb begin
    logic [4:0] f;
    bank_index_next  = bank_index;
    irq_enables_next = irq_enables;
    irq_flags_next   = irq_flags;
    mute_bit_next    = mute_bit;
    for (int i = 0; i < 4; i++) begin
      volume_latches_next[i]  = volume_latches[i];
      volumes_applied_next[i] = volumes_applied[i];
    end
    p_push  = 1'b0;
    p_pop   = 1'b0;
    p_flush = 1'b0;
    r_push  = 1'b0;
    r_pop   = 1'b0;
    s_push  = 1'b0;
    s_pop_n = 3'd0;
    src     = SRC_IMM;
    imm     = 8'd0;
    cmd_v   = 1'b0;
    cmd_c   = 8'd0;
    f       = irq_flags;

    case (opcode)
      OP_BUS_READ: begin
        case (reg_offset)
          PORT_STATUS: begin
            imm = {1'b0, s_nonempty, r_nonempty, !p_full, p_empty, 1'b0, bank_index};
          end
          PORT_RESPONSE: begin
            if (r_nonempty) begin
              r_pop = 1'b1;
              src   = SRC_RESP;
            end
          end
          PORT_DATA: begin
            if (s_nonempty) begin
              s_pop_n = 3'd1;
              src     = SRC_SECT;
            end
          end
          default: begin
            if (!bank_index[0]) begin
              imm = IRQ_READ_ONES | {3'b000, irq_enables};
            end else begin
              imm = IRQ_READ_ONES | {3'b000, irq_flags & FLAG_HI_MASK}
                  | {5'b00000, lowest_flag(irq_flags)};
            end
          end
        endcase
      end
      OP_BUS_WRITE: begin
        case (reg_offset)
          PORT_STATUS: begin
            bank_index_next = write_data[1:0];
          end
          PORT_RESPONSE: begin
            if (bank_index == BANK0) begin
              cmd_v = 1'b1;
              cmd_c = write_data;
            end else if (bank_index == BANK3) begin
              volume_latches_next[3] = write_data;
            end
          end
          PORT_DATA: begin
            case (bank_index)
              BANK0: p_push = !p_full;
              BANK1: irq_enables_next = write_data[4:0];
              BANK2: volume_latches_next[0] = write_data;
              default: volume_latches_next[2] = write_data;
            endcase
          end
          default: begin
            case (bank_index)
              BANK1: begin
                // Acknowledge: all three low bits set clears the lowest set flag.
                if (write_data[2:0] == ACK_LOWEST) begin
                  f = f & (f - 5'd1);
                end
                if (write_data[FLAG_END]) f[FLAG_END] = 1'b0;
                if (write_data[FLAG_ERROR]) f[FLAG_ERROR] = 1'b0;
                irq_flags_next = f;
                p_flush = write_data[ACK_FLUSH_BIT];
              end
              BANK2: volume_latches_next[1] = write_data;
              BANK3: begin
                mute_bit_next = write_data[0];
                if (write_data[APPLY_BIT]) begin
                  for (int i = 0; i < 4; i++) begin
                    volumes_applied_next[i] = volume_latches[i];
                  end
                end
              end
              default: ;
            endcase
          end
        endcase
      end
      OP_DMA_READ: begin
        src = SRC_SECT;
        if (sector_count >= SCW'(4)) begin
          s_pop_n = 3'd4;
        end else begin
          s_pop_n = sector_count[2:0];
        end
      end
      OP_PUSH_RESPONSE: r_push = !r_full;
      OP_PUSH_DATA:     s_push = !s_full;
      OP_RAISE_FLAG: begin
        if (write_data inside {[FLAG_NUM_MIN:FLAG_NUM_MAX]}) begin
          irq_flags_next = irq_flags | 5'(5'd1 << (write_data[2:0] - 3'd1));
        end
      end
      OP_POP_PARAM: begin
        if (!p_empty) begin
          p_pop = 1'b1;
          src   = SRC_PARAM;
        end
      end
      default: ;
    endcase
  end

  // Indices of the next four data FIFO entries, wrapped at the depth.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s_idx[k] = {1'b0, s_head} + (SW + 1)'(k);
      if (s_idx[k] >= (SW + 1)'(SECTOR_DEPTH)) begin
        s_idx[k] = s_idx[k] - (SW + 1)'(SECTOR_DEPTH);
      end
    end
    s_head_sum = {1'b0, s_head} + (SW + 1)'(s_pop_n);
    if (s_head_sum >= (SW + 1)'(SECTOR_DEPTH)) begin
      s_head_sum = s_head_sum - (SW + 1)'(SECTOR_DEPTH);
    end
  end

  // Snapshot of the result fields that do not come from a memory.
  always_comb begin
    a_stage_next.src       = src;
    a_stage_next.imm       = imm;
    a_stage_next.lane      = s_head[1:0];
    a_stage_next.nbytes    = s_pop_n;
    a_stage_next.cmd_valid = cmd_v;
    a_stage_next.cmd_code  = cmd_c;
    a_stage_next.irq       = (irq_flags_next & irq_enables_next) != 5'd0;
    a_stage_next.vol0      = volumes_applied_next[0];
    a_stage_next.vol1      = volumes_applied_next[1];
    a_stage_next.vol2      = volumes_applied_next[2];
    a_stage_next.vol3      = volumes_applied_next[3];
    a_stage_next.mute      = mute_bit_next;
  end

  // Apart from reset, state registers change only when an item is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      bank_index     <= '0;
      irq_enables    <= '0;
      irq_flags      <= '0;
      mute_bit       <= 1'b0;
      p_head         <= '0;
      p_tail         <= '0;
      param_count    <= '0;
      r_head         <= '0;
      r_tail         <= '0;
      response_count <= '0;
      s_head         <= '0;
      s_tail         <= '0;
      sector_count   <= '0;
      for (int i = 0; i < 4; i++) begin
        volume_latches[i]  <= '0;
        volumes_applied[i] <= '0;
      end
    end else if (accept) begin
      bank_index  <= bank_index_next;
      irq_enables <= irq_enables_next;
      irq_flags   <= irq_flags_next;
      mute_bit    <= mute_bit_next;
      for (int i = 0; i < 4; i++) begin
        volume_latches[i]  <= volume_latches_next[i];
        volumes_applied[i] <= volumes_applied_next[i];
      end

      if (p_flush) begin
        p_head      <= '0;
        p_tail      <= '0;
        param_count <= '0;
      end else if (p_push) begin
        p_tail      <= (p_tail == PW'(PARAM_DEPTH - 1)) ? '0 : p_tail + PW'(1);
        param_count <= param_count + PCW'(1);
      end else if (p_pop) begin
        p_head      <= (p_head == PW'(PARAM_DEPTH - 1)) ? '0 : p_head + PW'(1);
        param_count <= param_count - PCW'(1);
      end

      if (r_push) begin
        r_tail         <= (r_tail == RW'(RESPONSE_DEPTH - 1)) ? '0 : r_tail + RW'(1);
        response_count <= response_count + RCW'(1);
      end else if (r_pop) begin
        r_head         <= (r_head == RW'(RESPONSE_DEPTH - 1)) ? '0 : r_head + RW'(1);
        response_count <= response_count - RCW'(1);
      end

      if (s_push) begin
        s_tail       <= (s_tail == SW'(SECTOR_DEPTH - 1)) ? '0 : s_tail + SW'(1);
        sector_count <= sector_count + SCW'(1);
      end else begin
        s_head       <= s_head_sum[SW-1:0];
        sector_count <= sector_count - SCW'(s_pop_n);
      end
    end
  end

  // FIFO memories. The parameter and response FIFOs are one RAM each.
  cdhri_ram #(
    .WIDTH (8),
    .DEPTH (PARAM_DEPTH)
  ) u_param_ram (
    .clk     (clk),
    .wr_en   (accept && p_push),
    .wr_addr (p_tail),
    .wr_data (write_data),
    .rd_en   (accept && p_pop),
    .rd_addr (p_head),
    .rd_data (param_q)
  );

  cdhri_ram #(
    .WIDTH (8),
    .DEPTH (RESPONSE_DEPTH)
  ) u_resp_ram (
    .clk     (clk),
    .wr_en   (accept && r_push),
    .wr_addr (r_tail),
    .wr_data (write_data),
    .rd_en   (accept && r_pop),
    .rd_addr (r_head),
    .rd_data (resp_q)
  );

  // The data FIFO is four interleaved banks; entry i lives in bank i mod 4 at row i / 4.
  for (genvar b = 0; b < 4; b++) begin : g_sect_bank
    logic [1:0] k_sel;
    logic       rd_en;

    // Which of the next four entries falls into this bank.
    assign k_sel = 2'(b) - s_head[1:0];
    assign rd_en = accept && ({1'b0, k_sel} < s_pop_n);

    cdhri_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_sect_ram (
      .clk     (clk),
      .wr_en   (accept && s_push && (s_tail[1:0] == 2'(b))),
      .wr_addr (s_tail[SW-1:2]),
      .wr_data (write_data),
      .rd_en   (rd_en),
      .rd_addr (s_idx[k_sel][SW-1:2]),
      .rd_data (sect_q[b])
    );
  end

  // Read stage. It moves on whenever the output buffer has room or is being drained.
  assign out_pop = out_valid && !out_stall;
  assign a_move  = a_valid && ((q_count != 2'd2) || out_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_stage <= a_stage_next;
    end
  end

  // Result assembly from the registered RAM outputs. DMA bytes beyond the FIFO fill read 0.
  always_comb begin
    asm_result.rd = 32'd0;
    case (a_stage.src)
      SRC_RESP:  asm_result.rd = {24'd0, resp_q};
      SRC_PARAM: asm_result.rd = {24'd0, param_q};
      SRC_SECT: begin
        for (int k = 0; k < 4; k++) begin
          if (3'(k) < a_stage.nbytes) begin
            asm_result.rd[8*k +: 8] = sect_q[a_stage.lane + 2'(k)];
          end
        end
      end
      default:   asm_result.rd = {24'd0, a_stage.imm};
    endcase
    asm_result.cmd_valid = a_stage.cmd_valid;
    asm_result.cmd_code  = a_stage.cmd_code;
    asm_result.irq       = a_stage.irq;
    asm_result.vol0      = a_stage.vol0;
    asm_result.vol1      = a_stage.vol1;
    asm_result.vol2      = a_stage.vol2;
    asm_result.vol3      = a_stage.vol3;
    asm_result.mute      = a_stage.mute;
  end

  // Two-entry output buffer; q0 is the beat on offer.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= 2'd0;
    end else begin
      case ({a_move, out_pop})
        2'b10:   q_count <= q_count + 2'd1;
        2'b01:   q_count <= q_count - 2'd1;
        default: q_count <= q_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_pop) begin
      if (a_move && (q_count == 2'd1)) begin
        q0 <= asm_result;
      end else begin
        q0 <= q1;
      end
      if (a_move && (q_count == 2'd2)) begin
        q1 <= asm_result;
      end
    end else if (a_move) begin
      if (q_count == 2'd0) begin
        q0 <= asm_result;
      end else begin
        q1 <= asm_result;
      end
    end
  end

  assign out_valid          = (q_count != 2'd0);
  assign read_data          = q0.rd;
  assign command_valid      = q0.cmd_valid;
  assign command_code       = q0.cmd_code;
  assign irq_line           = q0.irq;
  assign vol_left_to_left   = q0.vol0;
  assign vol_left_to_right  = q0.vol1;
  assign vol_right_to_left  = q0.vol2;
  assign vol_right_to_right = q0.vol3;
  assign adpcm_mute         = q0.mute;

endmodule

`default_nettype wire

>>> rtl/core/cdhri_checker.sv
// Port-level checker of the disc host register block and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cdhri_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] read_data,
  input wire logic        command_valid,
  input wire logic [7:0]  command_code,
  input wire logic        irq_line
);

  // A result beat held back by the consumer keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(irq_line))
    else $error("stalled result beat changed");

  // After reset no result beat is offered.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat offered right after reset");

  // The input only stalls while results are waiting at the output.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  // A command write returns no read data, and no command code without a command.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && command_valid |-> read_data == 32'd0)
    else $error("command beat carries read data");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !command_valid |-> command_code == 8'd0)
    else $error("command code without command");

endmodule

bind cdrom_host_register_interface_unit cdhri_checker u_cdhri_checker (.*);

`default_nettype wire

>>> sim/cdrom_host_register_interface_unit_test.sv
// Self-checking testbench for the disc controller host register window.
`timescale 1ns / 1ps

module cdrom_host_register_interface_unit_test;
  import cdhri_pkg::*;

  // Sizes of the block as built with its default parameters.
  localparam int PARAM_DEPTH    = 16;
  localparam int RESPONSE_DEPTH = 16;
  localparam int SECTOR_DEPTH   = 4096;

  // Run control.
  localparam int RANDOM_BEATS  = 560;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_CYCLES   = 150;
  localparam int MAX_REPORTS   = 10;
  localparam int MAX_WAIT      = 11;

  // The one opcode the package leaves unnamed: the block treats it as a no-op.
  localparam logic [2:0] OP_NOP = 3'd7;

  // Interrupt flag numbers as the controller core raises them.
  localparam logic [7:0] FLAG_NUM_READY    = 8'd1;
  localparam logic [7:0] FLAG_NUM_COMPLETE = 8'd2;
  localparam logic [7:0] FLAG_NUM_ACK      = 8'd3;
  localparam logic [7:0] FLAG_NUM_END      = 8'd4;
  localparam logic [7:0] FLAG_NUM_ERROR    = 8'd5;

  // One input beat: what the host bus or the controller core does in one item.
  typedef struct packed {
    logic [2:0] op;
    logic [1:0] port;
    logic [7:0] data;
  } host_beat_t;

  // One output beat: read data, command strobe and the visible register state.
  typedef struct packed {
    logic [31:0] rdata;
    logic        cmd_valid;
    logic [7:0]  cmd_code;
    logic        irq;
    logic [7:0]  vol_ll;
    logic [7:0]  vol_lr;
    logic [7:0]  vol_rl;
    logic [7:0]  vol_rr;
    logic        mute;
  } window_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  opcode = OP_BUS_READ;
  logic [1:0]  reg_offset = PORT_STATUS;
  logic [7:0]  write_data = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] read_data;
  logic        command_valid;
  logic [7:0]  command_code;
  logic        irq_line;
  logic [7:0]  vol_left_to_left;
  logic [7:0]  vol_left_to_right;
  logic [7:0]  vol_right_to_left;
  logic [7:0]  vol_right_to_right;
  logic        adpcm_mute;

  cdrom_host_register_interface_unit u_top (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .opcode             (opcode),
    .reg_offset         (reg_offset),
    .write_data         (write_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .read_data          (read_data),
    .command_valid      (command_valid),
    .command_code       (command_code),
    .irq_line           (irq_line),
    .vol_left_to_left   (vol_left_to_left),
    .vol_left_to_right  (vol_left_to_right),
    .vol_right_to_left  (vol_right_to_left),
    .vol_right_to_right (vol_right_to_right),
    .adpcm_mute         (adpcm_mute)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the register window. It starts in the reset state, since reset is applied
  // once before the first beat.
  logic [1:0]       win_bank = BANK0;
  logic [4:0]       win_enables = '0;
  logic [4:0]       win_flags = '0;
  logic [3:0][7:0]  win_latch = '0;
  logic [3:0][7:0]  win_applied = '0;
  logic             win_mute = 1'b0;
  logic [7:0]       param_fifo[$];
  logic [7:0]       response_fifo[$];
  logic [7:0]       sector_fifo[$];

  window_result_t   predicted_outputs[$];
  host_beat_t       pending_beats[$];
  host_beat_t       next_beat;

  // Handshake bookkeeping: the fire flags hold whether a beat moved at the last rising edge,
  // so the falling-edge drivers know when to advance.
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int   tx_gap = 0;
  int   rx_wait = 0;
  int   idle_cycles = 0;
  int   mismatch_count = 0;
  int   random_beats = 0;

  // Idling controls set by the stimulus process.
  logic tx_no_idle = 1'b0;
  logic rx_no_idle = 1'b0;
  logic rx_hold_request = 1'b0;
  logic rx_hold = 1'b0;

  // Pops one byte of the sector-data FIFO; an empty FIFO reads as zero and stays empty.
  function automatic logic [7:0] pop_sector();
    if (sector_fifo.size() == 0) return 8'h00;
    return sector_fifo.pop_front();
  endfunction

  // Applies one accepted beat to the shadow window and queues the output beat it must give.
  function automatic void register_window_step(input host_beat_t b);
    window_result_t r;
    logic           hit;
    int             i;
    r = '0;
    hit = 1'b0;
    case (b.op)
      OP_BUS_READ: begin
        case (b.port)
          PORT_STATUS: begin
            r.rdata[7:0] = {1'b0, sector_fifo.size() != 0, response_fifo.size() != 0,
                            param_fifo.size() < PARAM_DEPTH, param_fifo.size() == 0,
                            1'b0, win_bank};
          end
          PORT_RESPONSE: begin
            if (response_fifo.size() != 0) r.rdata[7:0] = response_fifo.pop_front();
          end
          PORT_DATA: r.rdata[7:0] = pop_sector();
          default: begin
            // Even banks show the enables; odd banks show the flag number and the high flags.
            if (!win_bank[0]) begin
              r.rdata[7:0] = IRQ_READ_ONES | {3'b000, win_enables};
            end else begin
              r.rdata[7:0] = IRQ_READ_ONES | {3'b000, win_flags & FLAG_HI_MASK};
              for (i = 0; i < 5 && !hit; i++) begin
                if (win_flags[i]) begin
                  r.rdata[2:0] = 3'(i + 1);
                  hit = 1'b1;
                end
              end
            end
          end
        endcase
      end
      OP_BUS_WRITE: begin
        case (b.port)
          PORT_STATUS: win_bank = b.data[1:0];
          PORT_RESPONSE: begin
            if (win_bank == BANK0) begin
              r.cmd_valid = 1'b1;
              r.cmd_code  = b.data;
            end else if (win_bank == BANK3) begin
              win_latch[3] = b.data;
            end
          end
          PORT_DATA: begin
            case (win_bank)
              BANK0: if (param_fifo.size() < PARAM_DEPTH) param_fifo.push_back(b.data);
              BANK1: win_enables = b.data[4:0];
              BANK2: win_latch[0] = b.data;
              default: win_latch[2] = b.data;
            endcase
          end
          default: begin
            case (win_bank)
              BANK1: begin
                // Acknowledge: all three low bits clear the lowest pending flag.
                if (b.data[2:0] == ACK_LOWEST) begin
                  for (i = 0; i < 5 && !hit; i++) begin
                    if (win_flags[i]) begin
                      win_flags[i] = 1'b0;
                      hit = 1'b1;
                    end
                  end
                end
                if (b.data[FLAG_END]) win_flags[FLAG_END] = 1'b0;
                if (b.data[FLAG_ERROR]) win_flags[FLAG_ERROR] = 1'b0;
                if (b.data[ACK_FLUSH_BIT]) param_fifo.delete();
              end
              BANK2: win_latch[1] = b.data;
              BANK3: begin
                win_mute = b.data[0];
                if (b.data[APPLY_BIT]) win_applied = win_latch;
              end
              default: ;
            endcase
          end
        endcase
      end
      OP_DMA_READ: begin
        // First popped byte lands in the lowest byte of the word.
        r.rdata[7:0]   = pop_sector();
        r.rdata[15:8]  = pop_sector();
        r.rdata[23:16] = pop_sector();
        r.rdata[31:24] = pop_sector();
      end
      OP_PUSH_RESPONSE: begin
        if (response_fifo.size() < RESPONSE_DEPTH) response_fifo.push_back(b.data);
      end
      OP_PUSH_DATA: begin
        if (sector_fifo.size() < SECTOR_DEPTH) sector_fifo.push_back(b.data);
      end
      OP_RAISE_FLAG: begin
        if (b.data >= FLAG_NUM_MIN && b.data <= FLAG_NUM_MAX) win_flags[b.data - 1] = 1'b1;
      end
      OP_POP_PARAM: begin
        if (param_fifo.size() != 0) r.rdata[7:0] = param_fifo.pop_front();
      end
      default: ;
    endcase
    r.irq    = |(win_flags & win_enables);
    r.vol_ll = win_applied[0];
    r.vol_lr = win_applied[1];
    r.vol_rl = win_applied[2];
    r.vol_rr = win_applied[3];
    r.mute   = win_mute;
    predicted_outputs.push_back(r);
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("mismatch on %s: expected %h, got %h", field, want, got);
    end
  endtask

  // Compares the output beat on the ports with the oldest prediction.
  task automatic check_output_beat();
    window_result_t want;
    if (predicted_outputs.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("output beat with no prediction waiting: read_data %h", read_data);
    end else begin
      want = predicted_outputs.pop_front();
      compare_field("read_data", want.rdata, read_data);
      compare_field("command_valid", want.cmd_valid, command_valid);
      compare_field("command_code", want.cmd_code, command_code);
      compare_field("irq_line", want.irq, irq_line);
      compare_field("vol_left_to_left", want.vol_ll, vol_left_to_left);
      compare_field("vol_left_to_right", want.vol_lr, vol_left_to_right);
      compare_field("vol_right_to_left", want.vol_rl, vol_right_to_left);
      compare_field("vol_right_to_right", want.vol_rr, vol_right_to_right);
      compare_field("adpcm_mute", want.mute, adpcm_mute);
    end
  endtask

  // Monitor. Both channels are sampled at the rising edge, before the block's own nonblocking
  // updates land, so every prediction sees the beat exactly as the block accepted it. The
  // watchdog counts edges at which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= in_valid && !in_stall;
      out_fire <= out_valid && !out_stall;
      if (in_valid && !in_stall) register_window_step({opcode, reg_offset, write_data});
      if (out_valid && !out_stall) check_output_beat();
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("cdrom_host_register_interface_unit_test: done, errors");
        $finish;
      end
    end
  end

  // Sender. It moves on only once the current beat is taken, so a stalled payload holds still.
  // Each beat is followed by a drawn number of empty cycles, none while idling is switched off.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        next_beat = pending_beats.pop_front();
        opcode     <= next_beat.op;
        reg_offset <= next_beat.port;
        write_data <= next_beat.data;
        in_valid   <= 1'b1;
        tx_gap = tx_no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. After each taken beat it stalls for a drawn number of cycles; the long hold-off
  // overrides that while it runs.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_fire) rx_wait = rx_no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      else if (rx_wait > 0) rx_wait--;
      out_stall <= rx_hold || (rx_wait > 0);
    end
  end

  // Long receiver hold-off, counted here so that the sender keeps offering beats meanwhile and
  // the block has to fill its output buffer and stall its input.
  initial begin
    wait (rx_hold_request);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [1:0] rand_port();
    return 2'($urandom_range(0, 3));
  endfunction

  task automatic send(input logic [2:0] op, input logic [1:0] port, input logic [7:0] data);
    pending_beats.push_back({op, port, data});
    random_beats++;
  endtask

  // Bank select with random upper bits, which the block must ignore.
  task automatic choose_bank(input logic [1:0] bank);
    send(OP_BUS_WRITE, PORT_STATUS, (rand_byte() & 8'hFC) | {6'd0, bank});
  endtask

  // Sender pause: nothing more is offered until every predicted beat has come back.
  task automatic wait_for_quiet();
    while (pending_beats.size() != 0 || in_valid || predicted_outputs.size() != 0)
      @(posedge clk);
  endtask

  // A full command exchange: parameters in, command, the core pops parameters and answers,
  // raises a flag, and the host reads the flag and the response and acknowledges.
  task automatic command_exchange();
    int n_param;
    int n_resp;
    n_param = ($urandom_range(0, 3) == 0) ? $urandom_range(0, PARAM_DEPTH + 2)
                                          : $urandom_range(0, 6);
    n_resp  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, RESPONSE_DEPTH + 2)
                                          : $urandom_range(1, 4);
    choose_bank(BANK0);
    repeat (n_param) send(OP_BUS_WRITE, PORT_DATA, rand_byte());
    send(OP_BUS_READ, PORT_STATUS, rand_byte());
    send(OP_BUS_WRITE, PORT_RESPONSE, rand_byte());
    repeat ($urandom_range(0, n_param + 1)) send(OP_POP_PARAM, rand_port(), rand_byte());
    repeat (n_resp) send(OP_PUSH_RESPONSE, rand_port(), rand_byte());
    send(OP_RAISE_FLAG, rand_port(), 8'($urandom_range(FLAG_NUM_MIN, FLAG_NUM_MAX)));
    choose_bank(BANK1);
    send(OP_BUS_READ, PORT_IRQ, rand_byte());
    repeat ($urandom_range(0, n_resp + 1)) send(OP_BUS_READ, PORT_RESPONSE, rand_byte());
    if ($urandom_range(0, 3) != 0)
      send(OP_BUS_WRITE, PORT_IRQ, (rand_byte() & 8'hF8) | {5'd0, ACK_LOWEST});
    else
      send(OP_BUS_WRITE, PORT_IRQ, rand_byte());
  endtask

  // Sector data pushed by the core and drained by DMA words and single byte reads.
  task automatic sector_transfer();
    int n_data;
    n_data = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 9);
    repeat (n_data) send(OP_PUSH_DATA, rand_port(), rand_byte());
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 2))
        0: send(OP_DMA_READ, rand_port(), rand_byte());
        1: send(OP_BUS_READ, PORT_DATA, rand_byte());
        default: send(OP_BUS_READ, PORT_STATUS, rand_byte());
      endcase
    end
  endtask

  // All four volume latches, then an apply write that usually copies them over.
  task automatic volume_update();
    choose_bank(BANK2);
    send(OP_BUS_WRITE, PORT_DATA, rand_byte());
    send(OP_BUS_WRITE, PORT_IRQ, rand_byte());
    choose_bank(BANK3);
    send(OP_BUS_WRITE, PORT_RESPONSE, rand_byte());
    send(OP_BUS_WRITE, PORT_DATA, rand_byte());
    if ($urandom_range(0, 3) != 0)
      send(OP_BUS_WRITE, PORT_IRQ, rand_byte() | (8'd1 << APPLY_BIT));
    else
      send(OP_BUS_WRITE, PORT_IRQ, rand_byte());
  endtask

  // Enables, a few raised flags (now and then an out-of-range number), readback and ack.
  task automatic irq_exercise();
    choose_bank(BANK1);
    send(OP_BUS_WRITE, PORT_DATA, rand_byte());
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 5) == 0)
        send(OP_RAISE_FLAG, rand_port(), rand_byte());
      else
        send(OP_RAISE_FLAG, rand_port(), 8'($urandom_range(FLAG_NUM_MIN, FLAG_NUM_MAX)));
    end
    send(OP_BUS_READ, PORT_IRQ, rand_byte());
    send(OP_BUS_WRITE, PORT_IRQ, rand_byte());
    choose_bank(2'($urandom_range(0, 3)));
    send(OP_BUS_READ, PORT_IRQ, rand_byte());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: every FIFO empty, the no-op opcode, flag numbers out of range and all
    // five in range, a full acknowledge, the volume apply path and a short DMA word.
    send(OP_BUS_READ, PORT_STATUS, 8'h00);
    send(OP_BUS_READ, PORT_RESPONSE, 8'hFF);
    send(OP_BUS_READ, PORT_DATA, 8'h00);
    send(OP_DMA_READ, PORT_IRQ, 8'hFF);
    send(OP_POP_PARAM, PORT_STATUS, 8'h00);
    send(OP_NOP, PORT_IRQ, 8'hFF);
    send(OP_BUS_READ, PORT_IRQ, 8'h00);
    send(OP_BUS_WRITE, PORT_STATUS, 8'hFD);
    send(OP_BUS_WRITE, PORT_DATA, 8'hFF);
    send(OP_RAISE_FLAG, PORT_STATUS, 8'h00);
    send(OP_RAISE_FLAG, PORT_STATUS, 8'h06);
    send(OP_RAISE_FLAG, PORT_IRQ, 8'hFF);
    send(OP_RAISE_FLAG, PORT_DATA, FLAG_NUM_ERROR);
    send(OP_RAISE_FLAG, PORT_DATA, FLAG_NUM_END);
    send(OP_RAISE_FLAG, PORT_DATA, FLAG_NUM_ACK);
    send(OP_RAISE_FLAG, PORT_DATA, FLAG_NUM_COMPLETE);
    send(OP_RAISE_FLAG, PORT_DATA, FLAG_NUM_READY);
    send(OP_BUS_READ, PORT_IRQ, 8'h00);
    send(OP_BUS_WRITE, PORT_IRQ, 8'hFF);
    send(OP_BUS_WRITE, PORT_STATUS, 8'h03);
    send(OP_BUS_WRITE, PORT_RESPONSE, 8'hFF);
    send(OP_BUS_WRITE, PORT_IRQ, 8'h21);
    send(OP_BUS_WRITE, PORT_IRQ, 8'h00);
    send(OP_PUSH_DATA, PORT_STATUS, 8'hFF);
    send(OP_DMA_READ, PORT_STATUS, 8'h00);
    wait_for_quiet();

    // Back-pressure: the receiver holds off while the sender streams beats with no gaps, so
    // the output buffer fills and the input stalls. Then the sender pauses until it drains.
    tx_no_idle = 1'b1;
    rx_hold_request = 1'b1;
    command_exchange();
    sector_transfer();
    command_exchange();
    wait_for_quiet();
    tx_no_idle = 1'b0;

    // Random part, mostly well-formed exchanges with random content and some raw noise.
    // Each chunk is fed once the previous one is on its way, so the idling switches line up
    // with the beats they are meant for.
    random_beats = 0;
    while (random_beats < RANDOM_BEATS) begin
      tx_no_idle = ($urandom_range(0, 3) == 0);
      rx_no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: command_exchange();
        3, 4: sector_transfer();
        5: volume_update();
        6, 7: irq_exercise();
        default: begin
          repeat ($urandom_range(1, 6)) send(3'($urandom_range(0, 7)), rand_port(), rand_byte());
        end
      endcase
      if ($urandom_range(0, 7) == 0) wait_for_quiet();
      while (pending_beats.size() != 0) @(posedge clk);
    end
    wait_for_quiet();

    // A short tail of raw beats with idling back on at both sides.
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
    repeat (12) send(3'($urandom_range(0, 7)), rand_port(), rand_byte());

    // Let every prediction come back, then watch a little longer for stray output beats.
    wait_for_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("cdrom_host_register_interface_unit_test: done, clean");
    end else begin
      $display("cdrom_host_register_interface_unit_test: done, errors");
    end
    $finish;
  end

endmodule
